// ===== design/multi_key_index_sort_defines.svh =====
// Assertion macros used by the block's checked file.
`ifndef MULTI_KEY_INDEX_SORT_DEFINES_SVH
`define MULTI_KEY_INDEX_SORT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MKIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mkis check failed");

// Check that a condition implies another one on the next edge.
`define MKIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkis next-cycle check failed");

`endif

// ===== design/mkis_pkg.sv =====
package mkis_pkg;

  localparam int unsigned ChannelW   = 10;
  localparam int unsigned PeakW      = 32;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned MaxEntries = 64;

  // One stored record.
  typedef struct packed {
    logic [ChannelW-1:0]     channel;
    logic signed [PeakW-1:0] peak;
    logic [IndexW-1:0]       index;
  } rec_t;

  // Row-wide controls handed to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // True if stored record s sorts after new record n (equal keys: new goes last).
  function automatic logic goes_after(rec_t s, rec_t n);
    logic res;
    if (s.channel != n.channel) begin
      res = s.channel > n.channel;
    end else begin
      res = $signed(s.peak) > $signed(n.peak);
    end
    return res;
  endfunction

endpackage

// ===== design/mkis_if.sv =====
// Record request channel.
interface mkis_in_if;
  logic                              valid;
  logic                              ready;
  logic [mkis_pkg::ChannelW-1:0]     channel;
  logic signed [mkis_pkg::PeakW-1:0] peak;
  logic                              last;

  modport source (output valid, output channel, output peak, output last, input ready);
  modport sink   (input valid, input channel, input peak, input last, output ready);
endinterface

// Sorted index request channel.
interface mkis_out_if;
  logic                            valid;
  logic                            ready;
  logic [mkis_pkg::IndexW-1:0]     index;
  logic                            final_res;
  logic                            dropped;

  modport source (output valid, output index, output final_res, output dropped, input ready);
  modport sink   (input valid, input index, input final_res, input dropped, output ready);
endinterface

// ===== design/mkis_cell.sv =====
module mkis_cell (
  input  logic                 clk_i,
  input  logic                 occupied_i,
  input  mkis_pkg::cell_ctrl_t ctrl_i,
  input  mkis_pkg::rec_t       new_rec_i,
  input  logic                 left_gt_i,
  input  mkis_pkg::rec_t       left_rec_i,
  input  mkis_pkg::rec_t       right_rec_i,
  output logic                 gt_o,
  output mkis_pkg::rec_t       rec_o
);

  mkis_pkg::rec_t rec_q, rec_d;

  // An empty cell sorts after everything.
  assign gt_o = !occupied_i || mkis_pkg::goes_after(rec_q, new_rec_i);

  // Insert: take the new record at the boundary, else move right by one.
  // Drain: take the right neighbor's record.
  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.shift) begin
      rec_d = right_rec_i;
    end else if (ctrl_i.insert && gt_o) begin
      rec_d = left_gt_i ? left_rec_i : new_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== design/multi_key_index_sort.sv =====
// Channel  Dir  Contents                     Accepted when
// in_i     in   channel, peak, last          valid && ready
// out_o    out  index, final_res, dropped    valid && ready
//
// Loading takes one record per cycle: each new record is compared in all
// cells at once and the row shifts right behind its slot in the same cycle.
// After the record marked last, the row shifts left once per taken result,
// with in_i.ready low while it drains; each result passes through the
// single output register fed from cell 0.
// Reset clears the record count, the overflow flag and the output valid.
// A stalled output holds the drain; input may resume while the final result waits.
`include "multi_key_index_sort_defines.svh"

module multi_key_index_sort #(
  parameter int unsigned MAX_ENTRIES = mkis_pkg::MaxEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mkis_in_if.sink          in_i,
  mkis_out_if.source       out_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic                 state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [mkis_pkg::IndexW-1:0] out_index_q, out_index_d;
  logic                 out_final_q, out_final_d;
  logic                 out_drop_q, out_drop_d;

  logic                 in_fire, full, pop;
  mkis_pkg::cell_ctrl_t ctrl;
  mkis_pkg::rec_t       new_rec;
  mkis_pkg::rec_t       cell_rec [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_gt;
  logic [MAX_ENTRIES-1:0] occupied;

  assign in_i.ready = (state_q == StLoad);
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(MAX_ENTRIES));
  assign pop        = (state_q == StDrain) && (!out_valid_q || out_o.ready);

  assign new_rec.channel = in_i.channel;
  assign new_rec.peak    = in_i.peak;
  assign new_rec.index   = mkis_pkg::IndexW'(count_q);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = pop;

  // Cell row
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    assign occupied[k] = CntW'(k) < count_q;

    mkis_cell u_cell (
      .clk_i       (clk_i),
      .occupied_i  (occupied[k]),
      .ctrl_i      (ctrl),
      .new_rec_i   (new_rec),
      .left_gt_i   ((k == 0) ? 1'b0 : cell_gt[(k == 0) ? 0 : k - 1]),
      .left_rec_i  (cell_rec[(k == 0) ? 0 : k - 1]),
      .right_rec_i ((k == MAX_ENTRIES - 1) ? '0 :
                    cell_rec[(k == MAX_ENTRIES - 1) ? k : k + 1]),
      .gt_o        (cell_gt[k]),
      .rec_o       (cell_rec[k])
    );
  end

  // Sequencer: count records while loading, count down while draining
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.last) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (pop) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = StLoad;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Output register: load from cell 0 on pop, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_final_d = out_final_q;
    out_drop_d  = out_drop_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_index_d = cell_rec[0].index;
      out_final_d = (count_q == CntW'(1));
      out_drop_d  = ovf_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_final_q <= out_final_d;
    out_drop_q  <= out_drop_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.index     = out_index_q;
  assign out_o.final_res = out_final_q;
  assign out_o.dropped   = out_drop_q;

  // Checks
  `MKIS_ASSERT(a_count_bound, count_q <= CntW'(MAX_ENTRIES))
  `MKIS_ASSERT_NEXT(a_last_drains, in_fire && in_i.last,
                    state_q == StDrain && count_q != '0)
  `MKIS_ASSERT_NEXT(a_final_empties, pop && count_q == CntW'(1),
                    state_q == StLoad && count_q == '0 && !ovf_q && out_o.final_res)

endmodule

// ===== dv/sort_order_check.sv =====
module sort_order_check
  import mkis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mkis_in_if          in_i,
  mkis_out_if         out_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected sorted index with its flags
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              final_res;
    logic              dropped;
  } rank_entry_t;

  rec_t        sorted_row[MaxEntries];
  int unsigned row_fill = 0;
  bit          list_lost = 1'b0;
  rank_entry_t rank_q[$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;

  // Channel, then signed peak as an unsigned value with the sign bit flipped
  function automatic logic [ChannelW+PeakW-1:0] order_key(rec_t r);
    return {r.channel, ~r.peak[PeakW-1], r.peak[PeakW-2:0]};
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] sort order mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Insert a record behind all equal keys; emit the row on last
  task automatic load_record(input logic [ChannelW-1:0] ch,
                             input logic signed [PeakW-1:0] pk, input logic lst);
    rec_t        fresh;
    int          pos;
    rank_entry_t ent;
    if (row_fill < MaxEntries) begin
      fresh.channel = ch;
      fresh.peak    = pk;
      fresh.index   = IndexW'(row_fill);
      pos = row_fill;
      while (pos > 0 && order_key(sorted_row[pos-1]) > order_key(fresh)) begin
        sorted_row[pos] = sorted_row[pos-1];
        pos--;
      end
      sorted_row[pos] = fresh;
      row_fill++;
    end else begin
      list_lost = 1'b1;
    end
    if (lst) begin
      for (int k = 0; k < row_fill; k++) begin
        ent.index     = sorted_row[k].index;
        ent.final_res = (k + 1 == row_fill);
        ent.dropped   = list_lost;
        rank_q.push_back(ent);
      end
      row_fill  = 0;
      list_lost = 1'b0;
    end
  endtask

  // Check results against the oldest expectation, then absorb new records
  always @(posedge clk_i) begin
    rank_entry_t want;
    if (rst_ni) begin
      if (out_i.valid && out_i.ready) begin
        if (rank_q.size() == 0) begin
          report_mismatch("result with nothing pending, index", 32'(out_i.index), 32'd0);
        end else begin
          want = rank_q.pop_front();
          checked++;
          if (out_i.index !== want.index) begin
            report_mismatch("index", 32'(out_i.index), 32'(want.index));
          end
          if (out_i.final_res !== want.final_res) begin
            report_mismatch("final_res", 32'(out_i.final_res), 32'(want.final_res));
          end
          if (out_i.dropped !== want.dropped) begin
            report_mismatch("dropped", 32'(out_i.dropped), 32'(want.dropped));
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        load_record(in_i.channel, in_i.peak, in_i.last);
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= rank_q.size();
    checked_o  <= checked;
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mkis_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  mkis_in_if  rec_if ();
  mkis_out_if idx_if ();

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  int unsigned burst_left = 0;
  int unsigned records_sent = 0;
  int unsigned lists_sent = 0;
  int unsigned lists_over = 0;
  int unsigned list_len = 0;

  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  logic [3:0]  stall_phase = '0;

  multi_key_index_sort uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rec_if),
    .out_o  (idx_if)
  );

  sort_order_check order_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (rec_if),
    .out_i      (idx_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    #10ns clk_i = 1'b1;
    #10ns clk_i = 1'b0;
  end

  // Receiver stalls: switch at random between four ready patterns
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        idx_if.ready <= 1'b1;
      end
      1: begin
        idx_if.ready <= ($urandom_range(0, 1) == 0);
      end
      2: begin
        idx_if.ready <= (stall_phase[1:0] == 2'd0);
      end
      default: begin
        idx_if.ready <= (stall_phase >= 4'd10);
      end
    endcase
    stall_phase <= stall_phase + 4'd1;
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rec_if.valid && rec_if.ready) || (idx_if.valid && idx_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no request accepted for %0d cycles", IdleLimit);
        $display("tb_top failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one record: open a new burst after a random gap, then hold until taken
  task automatic send_rec(input logic [ChannelW-1:0] ch, input logic signed [PeakW-1:0] pk,
                          input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        rec_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    rec_if.valid   <= 1'b1;
    rec_if.channel <= ch;
    rec_if.peak    <= pk;
    rec_if.last    <= lst;
    do @(posedge clk_i); while (!rec_if.ready);
    records_sent++;
    list_len++;
    if (lst) begin
      lists_sent++;
      if (list_len > MaxEntries) begin
        lists_over++;
      end
      list_len = 0;
    end
  endtask

  // Send a random record: full-range keys, clustered keys for ties, few channels with random peaks, or extremes
  task automatic send_rand(input logic lst);
    logic [ChannelW-1:0]     ch;
    logic signed [PeakW-1:0] pk;
    case ($urandom_range(0, 3))
      0: begin
        ch = $urandom_range(0, 3);
        pk = $urandom_range(0, 4);
        pk = pk - 32'sd2;
      end
      1: begin
        ch = $urandom_range(0, 3);
        pk = $urandom;
      end
      2: begin
        ch = $urandom_range(0, 1) ? '1 : '0;
        pk = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      end
      default: begin
        ch = $urandom_range(0, 1023);
        pk = $urandom;
      end
    endcase
    send_rec(ch, pk, lst);
  endtask

  // Send a random list of the given length
  task automatic send_list(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_rand(i + 1 == len);
    end
  endtask

  initial begin
    int unsigned len;
    rst_ni         <= 1'b0;
    rec_if.valid   <= 1'b0;
    rec_if.channel <= '0;
    rec_if.peak    <= '0;
    rec_if.last    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-record list
    send_rec(10'd0, 32'sd0, 1'b1);

    // Extreme keys, sign handling of the peak, and equal keys broken by arrival
    send_rec(10'd1023, 32'sh7fff_ffff, 1'b0);
    send_rec(10'd0, 32'sh8000_0000, 1'b0);
    send_rec(10'd1023, 32'sh8000_0000, 1'b0);
    send_rec(10'd0, 32'sh7fff_ffff, 1'b0);
    send_rec(10'd5, -32'sd1, 1'b0);
    send_rec(10'd5, 32'sd0, 1'b0);
    send_rec(10'd5, 32'sd1, 1'b0);
    send_rec(10'd5, 32'sd0, 1'b0);
    send_rec(10'd5, 32'sd0, 1'b0);
    send_rec(10'd0, 32'sh8000_0000, 1'b1);

    // Descending channels: every new record lands at the front of the row
    for (int i = 0; i < 6; i++) begin
      send_rec(10'(600 - 100 * i), 32'sd0, i == 5);
    end

    // Random lists, mostly short
    while (records_sent < 30) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      send_list(len);
    end

    // Fill the store, then overflow it with last on a dropped record
    send_list(MaxEntries + 1);
    send_list($urandom_range(1, 4));

    rec_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Loaded %0d records in %0d lists, %0d of them past capacity.",
             records_sent, lists_sent, lists_over);
    $display("Checked %0d sorted indices, %0d mismatches.", checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mkis_pkg.sv
design/mkis_if.sv
design/mkis_cell.sv
design/multi_key_index_sort.sv
dv/sort_order_check.sv
dv/tb_top.sv
